/* rtl/core/twsch_pkg.sv */
package twsch_pkg;

  localparam int WHEEL_SLOTS_DEF = 64;
  localparam int NUM_TIMERS_DEF  = 16;
  localparam int MAX_RESULTS     = 16;

  localparam int TIME_W    = 44;
  localparam int TPS_W     = 32;
  localparam int WSL_W     = 7;
  localparam int DIV_W     = TIME_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int ID_W      = 4;
  localparam int DLY_W     = 7;
  localparam int OSLOT_W   = 6;

  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_TICKS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOTS = 2'd1;

  localparam logic [TPS_W-1:0] TPS_RESET = 32'd2000;
  localparam logic [WSL_W-1:0] WSL_RESET = 7'd64;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_DEL  = 2'd1,
    ACT_TIME = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_DEL = 2'd1,
    KIND_EXP = 2'd2
  } kind_e;

endpackage

/* rtl/core/timing_wheel_scheduler.sv */
// Single-level timing wheel over NUM_TIMERS timers with up to WHEEL_SLOTS
// slots. An add beat (tuser 0) arms a timer at (cursor + clamped delay)
// mod size and returns one acknowledge beat with the slot and applied
// delay; a delete beat (tuser 1) disarms it and returns one acknowledge
// beat. A time beat (tuser 2) turns the counter value into slot steps
// (at most one rotation) and returns one expiry beat for every armed timer
// in each slot reached, at most 16, the final beat marked by tlast; no
// beat comes back when nothing expires. Timers stay armed until deleted.
// Each item runs alone: an add waits while the bit-serial divider
// reduces the slot modulo the wheel size, and a time update waits for
// the 45-step division and then reads the whole timer store for every
// slot stepped, one entry per cycle unless an expiry beat stalls the
// scan. Expiry beats stall the scan when the master side is not ready.
// After reset a clearing pass runs over every entry of the timer store
// before the first item is taken; configuration writes are taken in any
// cycle and belong only where the block is idle, between items.
module timing_wheel_scheduler
  import twsch_pkg::*;
#(
  parameter int WHEEL_SLOTS = WHEEL_SLOTS_DEF,
  parameter int NUM_TIMERS  = NUM_TIMERS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [TPS_W-1:0]      cfg_data_i,
  // input beats
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [55:0]           s_tdata,   // timer_id[3:0], delay_slots[11:4], time_now[55:12]
  input  logic [1:0]            s_tuser,   // action[1:0]
  // result beats
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // timer_id_res[3:0], delay_applied[10:4], slot[16:11]
  output logic [1:0]            m_tuser,   // kind[1:0]
  output logic                  m_tlast
);

  localparam int SLOT_W    = $clog2(WHEEL_SLOTS);
  localparam int SIZE_W    = $clog2(WHEEL_SLOTS + 1);
  localparam int SZ_CMP_W  = (SIZE_W > WSL_W) ? SIZE_W : WSL_W;
  localparam int SUM_W     = ((SLOT_W > DLY_W) ? SLOT_W : DLY_W) + 1;
  localparam int TID_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TCNT_W    = $clog2(NUM_TIMERS + 1);
  localparam int ENT_W     = SLOT_W + 1;
  localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_ADIV,
    ST_ELAP,
    ST_TDIV,
    ST_TWAIT,
    ST_STEP,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e                 state_q, state_d;
  logic [TCNT_W-1:0]      clr_cnt_q, clr_cnt_d;
  logic [ID_W-1:0]        id_q, id_d;
  logic [DLY_W-1:0]       dly_q, dly_d;
  logic [TIME_W-1:0]      now_q, now_d;
  logic [TIME_W-1:0]      diff_q, diff_d;
  logic [DIV_W-1:0]       elapse_q, elapse_d;
  logic [TIME_W-1:0]      last_time_q, last_time_d;
  logic [TPS_W-1:0]       left_q, left_d;
  logic [TPS_W-1:0]       tps_q, tps_d;
  logic [WSL_W-1:0]       wsl_q, wsl_d;
  logic [SLOT_W-1:0]      cursor_q, cursor_d;
  logic [SIZE_W-1:0]      step_left_q, step_left_d;
  logic [TCNT_W-1:0]      rd_cnt_q, rd_cnt_d;
  logic                   cmp_v_q, cmp_v_d;
  logic [TID_W-1:0]       cmp_idx_q, cmp_idx_d;
  logic [RES_CNT_W-1:0]   n_q, n_d;
  logic                   pend_v_q, pend_v_d;
  kind_e                  pend_kind_q, pend_kind_d;
  logic [ID_W-1:0]        pend_id_q, pend_id_d;
  logic [DLY_W-1:0]       pend_dly_q, pend_dly_d;
  logic [OSLOT_W-1:0]     pend_slot_q, pend_slot_d;
  logic                   out_v_q, out_v_d;
  kind_e                  out_kind_q, out_kind_d;
  logic [ID_W-1:0]        out_id_q, out_id_d;
  logic [DLY_W-1:0]       out_dly_q, out_dly_d;
  logic [OSLOT_W-1:0]     out_slot_q, out_slot_d;
  logic                   out_last_q, out_last_d;

  logic                   mem_we;
  logic [TID_W-1:0]       mem_waddr;
  logic [ENT_W-1:0]       mem_wdata;
  logic                   mem_re;
  logic [TID_W-1:0]       mem_raddr;
  logic [ENT_W-1:0]       mem_rdata;

  logic                   div_start;
  logic [DIV_CNT_W-1:0]   div_msb;
  logic [DIV_W-1:0]       div_dvd;
  logic [TPS_W-1:0]       div_dvs;
  logic                   div_done;
  logic [DIV_W-1:0]       div_quo;
  logic [TPS_W-1:0]       div_rem;

  logic [SZ_CMP_W-1:0]    wsl_ext;
  logic [SIZE_W-1:0]      size;
  logic [SIZE_W-1:0]      cur_inc;
  logic [SLOT_W-1:0]      cur_next;
  logic [ID_W-1:0]        in_id;
  logic [7:0]             in_dly;
  logic [TIME_W-1:0]      in_now;
  logic                   in_id_ok;
  logic [DLY_W-1:0]       dly_clamp;
  logic [SUM_W-1:0]       add_sum;
  logic                   out_free;
  logic                   hit;
  logic                   stall;
  logic                   issue;

  assign in_id  = s_tdata[3:0];
  assign in_dly = s_tdata[11:4];
  assign in_now = s_tdata[55:12];

  assign cfg_ready_o = 1'b1;
  assign s_tready    = (state_q == ST_IDLE);
  assign out_free    = !out_v_q || m_tready;

  always_comb begin
    wsl_ext = SZ_CMP_W'(wsl_q);
    if (wsl_q == '0) begin
      size = SIZE_W'(1);
    end else if (wsl_ext > SZ_CMP_W'(WHEEL_SLOTS)) begin
      size = SIZE_W'(WHEEL_SLOTS);
    end else begin
      size = SIZE_W'(wsl_ext);
    end
    cur_inc  = SIZE_W'(cursor_q) + 1'b1;
    cur_next = (cur_inc >= size) ? '0 : SLOT_W'(cur_inc);
    in_id_ok = {{(32-ID_W){1'b0}}, in_id} < 32'(NUM_TIMERS);
    if (in_dly[7]) begin
      dly_clamp = DLY_W'(1);
    end else if (SZ_CMP_W'(in_dly[6:0]) > SZ_CMP_W'(size)) begin
      dly_clamp = DLY_W'(size);
    end else begin
      dly_clamp = in_dly[6:0];
    end
    add_sum = SUM_W'(cursor_q) + SUM_W'(dly_clamp);
    hit     = cmp_v_q && mem_rdata[SLOT_W] && (mem_rdata[SLOT_W-1:0] == cursor_q)
              && (n_q < RES_CNT_W'(MAX_RESULTS));
    stall   = hit && pend_v_q && !out_free;
    issue   = rd_cnt_q < TCNT_W'(NUM_TIMERS);
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    id_d        = id_q;
    dly_d       = dly_q;
    now_d       = now_q;
    diff_d      = diff_q;
    elapse_d    = elapse_q;
    last_time_d = last_time_q;
    left_d      = left_q;
    tps_d       = tps_q;
    wsl_d       = wsl_q;
    cursor_d    = cursor_q;
    step_left_d = step_left_q;
    rd_cnt_d    = rd_cnt_q;
    cmp_v_d     = cmp_v_q;
    cmp_idx_d   = cmp_idx_q;
    n_d         = n_q;
    pend_v_d    = pend_v_q;
    pend_kind_d = pend_kind_q;
    pend_id_d   = pend_id_q;
    pend_dly_d  = pend_dly_q;
    pend_slot_d = pend_slot_q;
    out_v_d     = out_v_q && !m_tready;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_dly_d   = out_dly_q;
    out_slot_d  = out_slot_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    div_start   = 1'b0;
    div_msb     = '0;
    div_dvd     = '0;
    div_dvs     = '0;

    if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_TICKS: tps_d = cfg_data_i;
        REG_SLOTS: wsl_d = cfg_data_i[WSL_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q[TID_W-1:0];
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == TCNT_W'(NUM_TIMERS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            ACT_ADD: begin
              if (in_id_ok) begin
                id_d      = in_id;
                dly_d     = dly_clamp;
                div_start = 1'b1;
                div_msb   = DIV_CNT_W'(SUM_W - 1);
                div_dvd   = DIV_W'(add_sum);
                div_dvs   = TPS_W'(size);
                state_d   = ST_ADIV;
              end
            end
            ACT_DEL: begin
              if (in_id_ok) begin
                mem_we      = 1'b1;
                mem_waddr   = TID_W'(in_id);
                pend_v_d    = 1'b1;
                pend_kind_d = KIND_DEL;
                pend_id_d   = in_id;
                pend_dly_d  = '0;
                pend_slot_d = '0;
                state_d     = ST_FLUSH;
              end
            end
            ACT_TIME: begin
              now_d   = in_now;
              diff_d  = in_now - last_time_q;
              state_d = ST_ELAP;
            end
            default: ;
          endcase
        end
      end
      ST_ADIV: begin
        if (div_done) begin
          mem_we      = 1'b1;
          mem_waddr   = TID_W'(id_q);
          mem_wdata   = {1'b1, div_rem[SLOT_W-1:0]};
          pend_v_d    = 1'b1;
          pend_kind_d = KIND_ADD;
          pend_id_d   = id_q;
          pend_dly_d  = dly_q;
          pend_slot_d = OSLOT_W'(div_rem[SLOT_W-1:0]);
          state_d     = ST_FLUSH;
        end
      end
      ST_ELAP: begin
        elapse_d = DIV_W'(diff_q) + DIV_W'(left_q);
        state_d  = ST_TDIV;
      end
      ST_TDIV: begin
        if (elapse_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          div_start = 1'b1;
          div_msb   = DIV_CNT_W'(DIV_W - 1);
          div_dvd   = elapse_q - 1'b1;
          div_dvs   = (tps_q == '0) ? TPS_W'(1) : tps_q;
          state_d   = ST_TWAIT;
        end
      end
      ST_TWAIT: begin
        if (div_done) begin
          if (div_quo == '0) begin
            state_d = ST_IDLE;
          end else begin
            left_d      = div_rem + 1'b1;
            last_time_d = now_q;
            step_left_d = (div_quo > DIV_W'(size)) ? size : SIZE_W'(div_quo);
            n_d         = '0;
            state_d     = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        cursor_d = cur_next;
        rd_cnt_d = '0;
        cmp_v_d  = 1'b0;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        if (!stall) begin
          mem_re    = issue;
          mem_raddr = rd_cnt_q[TID_W-1:0];
          if (issue) begin
            rd_cnt_d = rd_cnt_q + 1'b1;
          end
          cmp_v_d   = issue;
          cmp_idx_d = rd_cnt_q[TID_W-1:0];
          if (hit) begin
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_kind_d = pend_kind_q;
              out_id_d   = pend_id_q;
              out_dly_d  = pend_dly_q;
              out_slot_d = pend_slot_q;
              out_last_d = 1'b0;
            end
            pend_v_d    = 1'b1;
            pend_kind_d = KIND_EXP;
            pend_id_d   = ID_W'(cmp_idx_q);
            pend_dly_d  = '0;
            pend_slot_d = OSLOT_W'(cursor_q);
            n_d         = n_q + 1'b1;
          end
          if (!issue && !cmp_v_q) begin
            if (step_left_q == SIZE_W'(1)) begin
              state_d = ST_FLUSH;
            end else begin
              step_left_d = step_left_q - 1'b1;
              state_d     = ST_STEP;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_kind_d = pend_kind_q;
          out_id_d   = pend_id_q;
          out_dly_d  = pend_dly_q;
          out_slot_d = pend_slot_q;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_cnt_q   <= '0;
      id_q        <= '0;
      dly_q       <= '0;
      now_q       <= '0;
      diff_q      <= '0;
      elapse_q    <= '0;
      last_time_q <= '0;
      left_q      <= '0;
      tps_q       <= TPS_RESET;
      wsl_q       <= WSL_RESET;
      cursor_q    <= '0;
      step_left_q <= '0;
      rd_cnt_q    <= '0;
      cmp_v_q     <= 1'b0;
      cmp_idx_q   <= '0;
      n_q         <= '0;
      pend_v_q    <= 1'b0;
      pend_kind_q <= KIND_ADD;
      pend_id_q   <= '0;
      pend_dly_q  <= '0;
      pend_slot_q <= '0;
      out_v_q     <= 1'b0;
      out_kind_q  <= KIND_ADD;
      out_id_q    <= '0;
      out_dly_q   <= '0;
      out_slot_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      id_q        <= id_d;
      dly_q       <= dly_d;
      now_q       <= now_d;
      diff_q      <= diff_d;
      elapse_q    <= elapse_d;
      last_time_q <= last_time_d;
      left_q      <= left_d;
      tps_q       <= tps_d;
      wsl_q       <= wsl_d;
      cursor_q    <= cursor_d;
      step_left_q <= step_left_d;
      rd_cnt_q    <= rd_cnt_d;
      cmp_v_q     <= cmp_v_d;
      cmp_idx_q   <= cmp_idx_d;
      n_q         <= n_d;
      pend_v_q    <= pend_v_d;
      pend_kind_q <= pend_kind_d;
      pend_id_q   <= pend_id_d;
      pend_dly_q  <= pend_dly_d;
      pend_slot_q <= pend_slot_d;
      out_v_q     <= out_v_d;
      out_kind_q  <= out_kind_d;
      out_id_q    <= out_id_d;
      out_dly_q   <= out_dly_d;
      out_slot_q  <= out_slot_d;
      out_last_q  <= out_last_d;
    end
  end

  twsch_store #(
    .DEPTH  (NUM_TIMERS),
    .DATA_W (ENT_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  twsch_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .msb_i       (div_msb),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign m_tvalid = out_v_q;
  assign m_tdata  = {7'd0, out_slot_q, out_dly_q, out_id_q};
  assign m_tuser  = out_kind_q;
  assign m_tlast  = out_last_q;

endmodule

/* rtl/core/twsch_div.sv */
module twsch_div
  import twsch_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_CNT_W-1:0] msb_i,
  input  logic [DIV_W-1:0]     dividend_i,
  input  logic [TPS_W-1:0]     divisor_i,
  output logic                 done_o,
  output logic [DIV_W-1:0]     quotient_o,
  output logic [TPS_W-1:0]     remainder_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [TPS_W-1:0]     dvs_q, dvs_d;
  logic [TPS_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [TPS_W:0]       trial;
  logic [TPS_W:0]       trial_sub;
  logic                 ge;

  always_comb begin
    trial     = {rem_q, dvd_q[cnt_q]};
    trial_sub = trial - {1'b0, dvs_q};
    ge        = trial >= {1'b0, dvs_q};
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    dvd_d     = dvd_q;
    dvs_d     = dvs_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = msb_i;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? trial_sub[TPS_W-1:0] : trial[TPS_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      dvd_q  <= dvd_d;
      dvs_q  <= dvs_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* rtl/core/twsch_store.sv */
module twsch_store #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 7
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/twsch_chk.sv */
module twsch_chk
  import twsch_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [23:0]           m_tdata,   // timer_id_res[3:0], delay_applied[10:4], slot[16:11]
  input logic [1:0]            m_tuser,   // kind[1:0]
  input logic                  m_tlast
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
    && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // acknowledges are single-beat results
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tuser == KIND_ADD || m_tuser == KIND_DEL) |-> m_tlast)
    else $error("acknowledge without tlast");

  a_del_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser == KIND_DEL |-> m_tdata[16:4] == '0)
    else $error("delete acknowledge with nonzero delay or slot");

  a_exp_dly: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser == KIND_EXP |-> m_tdata[10:4] == '0)
    else $error("expiry with nonzero delay");

endmodule

bind timing_wheel_scheduler twsch_chk u_chk (.*);

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import twsch_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 1400;
  localparam int DRAIN_LIMIT = 50000;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] id;
    logic [6:0] delay;
    logic [5:0] slot;
    logic       last;
  } beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [TPS_W-1:0]      cfg_data_i = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [55:0]           s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [23:0]           m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tlast;

  timing_wheel_scheduler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  always #6 clk_i = ~clk_i;

  // wheel state as the block should hold it
  logic [TPS_W-1:0]  cfg_ticks = TPS_RESET;
  logic [WSL_W-1:0]  cfg_slots = WSL_RESET;
  logic              arm_flag [NUM_TIMERS_DEF];
  logic [5:0]        arm_slot [NUM_TIMERS_DEF];
  int unsigned       wheel_pos = 0;
  logic [63:0]       carry_ticks = '0;
  logic [TIME_W-1:0] stamp = '0;

  beat_t pending_beats[$];
  int    errors = 0;
  int    items_sent = 0;
  int    beats_seen = 0;
  int    cfg_writes = 0;
  int    idle_pct = 20;
  int    stall_left = 0;
  bit    tx_held = 1'b0;
  bit    settle_due = 1'b0;

  function automatic int unsigned wheel_size();
    if (cfg_slots == 0) return 1;
    if (cfg_slots > WHEEL_SLOTS_DEF) return WHEEL_SLOTS_DEF;
    return 32'(cfg_slots);
  endfunction

  function automatic logic [63:0] slot_period();
    return (cfg_ticks == 0) ? 64'd1 : {32'd0, cfg_ticks};
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[TIME_W-1:0];
  endfunction

  // counter value roughly the given number of slot periods past the last update
  function automatic logic [TIME_W-1:0] time_after(int unsigned periods);
    logic [63:0] t;
    t = {20'd0, stamp} + slot_period() * periods + $urandom_range(3);
    return t[TIME_W-1:0];
  endfunction

  function automatic void expire_or_arm(logic [1:0] act, logic [3:0] id,
                                        logic signed [7:0] dly, logic [TIME_W-1:0] now);
    int unsigned size;
    int unsigned slot_v;
    int unsigned nsteps;
    int          d;
    int          n;
    beat_t       b;
    logic [63:0] per;
    logic [63:0] elapse;
    logic [63:0] due;
    size = wheel_size();
    b = '0;
    b.last = 1'b1;
    case (act)
      ACT_ADD: begin
        d = dly;
        if (d > int'(size)) d = size;
        if (d < 0) d = 1;
        slot_v = (wheel_pos + d) % size;
        arm_slot[id] = slot_v[5:0];
        arm_flag[id] = 1'b1;
        b.kind = KIND_ADD;
        b.id = id;
        b.delay = d[6:0];
        b.slot = slot_v[5:0];
        pending_beats.push_back(b);
      end
      ACT_DEL: begin
        arm_flag[id] = 1'b0;
        b.kind = KIND_DEL;
        b.id = id;
        pending_beats.push_back(b);
      end
      ACT_TIME: begin
        per = slot_period();
        elapse = {20'd0, now - stamp} + carry_ticks;
        due = (elapse == 0) ? 64'd0 : (elapse - 1) / per;
        if (due != 0) begin
          nsteps = (due > size) ? size : due[31:0];
          n = 0;
          for (int s = 0; s < nsteps; s++) begin
            wheel_pos++;
            if (wheel_pos >= size) wheel_pos = 0;
            for (int t = 0; t < NUM_TIMERS_DEF; t++) begin
              if (arm_flag[t] && arm_slot[t] == wheel_pos && n < MAX_RESULTS) begin
                b = '0;
                b.kind = KIND_EXP;
                b.id = t[3:0];
                b.slot = wheel_pos[5:0];
                pending_beats.push_back(b);
                n++;
              end
            end
          end
          if (n > 0) begin
            b = pending_beats.pop_back();
            b.last = 1'b1;
            pending_beats.push_back(b);
          end
          carry_ticks = elapse - due * per;
          stamp = now;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic hold_input();
    if (tx_held) begin
      s_tvalid <= 1'b0;
      tx_held = 1'b0;
    end
  endtask

  task automatic send_item(logic [1:0] act, logic [3:0] id, logic [7:0] dly,
                           logic [TIME_W-1:0] now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      hold_input();
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {now, dly, id};
    tx_held = 1'b1;
    do @(posedge clk_i); while (!s_tready);
    expire_or_arm(act, id, dly, now);
    items_sent++;
    settle_due = 1'b1;
  endtask

  task automatic wait_drained();
    hold_input();
    do @(posedge clk_i); while (pending_beats.size() != 0);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [TPS_W-1:0] data);
    wait_drained();
    // an update may still be stepping the wheel with nothing to report
    if (settle_due) begin
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      settle_due = 1'b0;
    end
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (addr == REG_TICKS) cfg_ticks = data;
    else if (addr == REG_SLOTS) cfg_slots = data[WSL_W-1:0];
    cfg_writes++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : rx_check
    beat_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result beat, expected none, got tuser %0d tdata %h",
                 $time, m_tuser, m_tdata);
      end else begin
        want = pending_beats.pop_front();
        check_field("kind", 32'(want.kind), 32'(m_tuser));
        check_field("timer_id", 32'(want.id), 32'(m_tdata[3:0]));
        check_field("delay_applied", 32'(want.delay), 32'(m_tdata[10:4]));
        check_field("slot", 32'(want.slot), 32'(m_tdata[16:11]));
        check_field("tlast", 32'(want.last), 32'(m_tlast));
      end
    end
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic test_directed_ops();
    idle_pct = 20;
    send_item(ACT_ADD, 4'd0, 8'd0, '0);
    send_item(ACT_ADD, 4'd15, 8'd127, TIME_MAX);
    send_item(ACT_ADD, 4'd1, 8'h80, '0);
    send_item(ACT_ADD, 4'd2, 8'hFF, TIME_MAX);
    send_item(ACT_ADD, 4'd3, 8'd5, '0);
    // moves timer 3
    send_item(ACT_ADD, 4'd3, 8'd8, '0);
    send_item(ACT_DEL, 4'd4, 8'hFF, TIME_MAX);
    send_item(ACT_NONE, 4'd15, 8'hFF, TIME_MAX);
    send_item(ACT_TIME, 4'd0, 8'd0, '0);
    send_item(ACT_TIME, 4'd0, 8'd0, 44'd2000);
    send_item(ACT_TIME, 4'd15, 8'hFF, 44'd2001);
    send_item(ACT_DEL, 4'd1, 8'd0, '0);
    send_item(ACT_TIME, 4'd0, 8'd0, time_after(7));
    send_item(ACT_TIME, 4'd0, 8'd0, TIME_MAX);
    wait_drained();
  endtask

  task automatic test_config_edges();
    cfg_write(REG_TICKS, 32'd0);
    cfg_write(REG_SLOTS, 32'd0);
    send_item(ACT_ADD, 4'd5, 8'd3, '0);
    send_item(ACT_TIME, 4'd0, 8'd0, time_after(1));
    cfg_write(REG_SLOTS, 32'd127);
    cfg_write(REG_TICKS, 32'hFFFF_FFFF);
    send_item(ACT_ADD, 4'd6, 8'd64, '0);
    send_item(ACT_ADD, 4'd7, 8'd127, '0);
    send_item(ACT_TIME, 4'd0, 8'd0, time_after(2));
    cfg_write(REG_TICKS, 32'd1);
    send_item(ACT_TIME, 4'd0, 8'd0, time_after(20));
    // cursor now sits beyond the reduced wheel
    cfg_write(REG_SLOTS, 32'd5);
    send_item(ACT_ADD, 4'd8, 8'hFB, '0);
    send_item(ACT_TIME, 4'd0, 8'd0, time_after(2));
    send_item(ACT_TIME, 4'd0, 8'd0, time_after(10));
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_traffic(int count, logic [TPS_W-1:0] ticks,
                                     logic [WSL_W-1:0] slots, int pct);
    int          done;
    int          r;
    int unsigned size;
    logic [7:0]  dly;
    cfg_write(REG_TICKS, ticks);
    cfg_write(REG_SLOTS, {25'd0, slots});
    idle_pct = pct;
    done = 0;
    while (done < count) begin
      size = wheel_size();
      r = $urandom_range(99);
      if ((done % 25) == 24) wait_drained();
      if (r < 4) begin
        // arm every timer, then sweep one whole rotation
        for (int t = 0; t < NUM_TIMERS_DEF; t++) begin
          dly = 8'($urandom_range(size + 1) - 1);
          send_item(ACT_ADD, t[3:0], dly, rand_time());
        end
        send_item(ACT_TIME, 4'd0, 8'd0, time_after(size + 1));
        done += NUM_TIMERS_DEF + 1;
      end else if (r < 40) begin
        if ($urandom_range(1)) dly = 8'($urandom_range(size + 1) - 1);
        else dly = 8'($urandom());
        send_item(ACT_ADD, 4'($urandom()), dly, rand_time());
        done++;
      end else if (r < 52) begin
        send_item(ACT_DEL, 4'($urandom()), 8'($urandom()), rand_time());
        done++;
      end else if (r < 57) begin
        send_item(ACT_NONE, 4'($urandom()), 8'($urandom()), rand_time());
      end else if (r < 62) begin
        send_item(ACT_TIME, 4'($urandom()), 8'($urandom()), rand_time());
        done++;
      end else begin
        send_item(ACT_TIME, 4'($urandom()), 8'($urandom()),
                  time_after($urandom_range(3)));
        done++;
      end
    end
  endtask

  initial begin
    int waited;
    for (int t = 0; t < NUM_TIMERS_DEF; t++) begin
      arm_flag[t] = 1'b0;
      arm_slot[t] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_ops();
    test_config_edges();
    test_random_traffic(22, $urandom_range(4, 1), 7'($urandom_range(8, 2)), 30);
    test_random_traffic(18, 32'd1, 7'd64, 0);
    test_random_traffic(22, $urandom(), 7'($urandom_range(127)), 50);
    test_random_traffic(28, $urandom_range(50, 1), 7'($urandom_range(16, 1)), 30);

    hold_input();
    waited = 0;
    while (pending_beats.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_beats.size() != 0) begin
      errors += pending_beats.size();
      $display("%0t ns: %0d result beats expected, got none", $time, pending_beats.size());
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("ran %0d input beats and %0d result beats through %0d register writes,",
             items_sent, beats_seen, cfg_writes);
    $display("covering clamped delays, moves, deletes, wraps, long gaps and full rotations");
    if (errors == 0) $display("PASS timing_wheel_scheduler");
    else $display("FAIL timing_wheel_scheduler");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("FAIL timing_wheel_scheduler");
    $finish;
  end

endmodule
